// File: sv/sha384_pkg.sv
package sha384_pkg;

  localparam int BlockBytes = 128;
  localparam int LenStart   = 112;
  localparam int DigestWords = 6;
  localparam int Rounds = 80;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic       final_block;
  } ctl_t;

  localparam logic [63:0] IV [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

  localparam logic [63:0] K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// File: sv/sha384_ram.sv
module sha384_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sha384_core.sv
// Compression engine: a load phase (128 buffer reads, the read latency and the
// last word write), then the rounds (each reads x15, x2, x7 and the current
// word from the window RAM), then an add step into the hash state.
module sha384_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha384_pkg::ctl_t      ctl,
  output logic [6:0]            buf_raddr,
  input  logic [7:0]            buf_rdata,
  output logic                  busy,
  output logic                  done,
  input  logic                  hash_init,
  input  logic [2:0]            dig_sel,
  output logic [63:0]           dig_word
);

  typedef enum logic [2:0] {C_IDLE, C_LOAD, C_R0, C_R1, C_R2, C_R3, C_ADD} cst_t;

  cst_t        cst, cst_next;
  logic [63:0] h [8];
  logic [63:0] v [8];
  logic [6:0]  rd_cnt;
  logic [7:0]  ld_cnt;
  logic [63:0] word_acc;
  logic [6:0]  rnd;
  logic [63:0] x15, x2, x7;
  logic [63:0] w_new;

  logic        w_we;
  logic [3:0]  w_waddr, w_raddr;
  logic [63:0] w_wdata, w_rdata;

  sha384_ram #(.Width(64), .Depth(16)) u_win (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  logic [63:0] sig0, sig1, w_cur, s1, ch, s0, mj, t1, t2;

  always_comb begin
    sig0 = sha384_pkg::rotr(x15, 1) ^ sha384_pkg::rotr(x15, 8) ^ (x15 >> 7);
    sig1 = sha384_pkg::rotr(x2, 19) ^ sha384_pkg::rotr(x2, 61) ^ (x2 >> 6);
    w_new = w_rdata + sig0 + x7 + sig1;
    w_cur = (rnd >= 7'd16) ? w_new : w_rdata;
    s1 = sha384_pkg::rotr(v[4], 14) ^ sha384_pkg::rotr(v[4], 18) ^ sha384_pkg::rotr(v[4], 41);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + sha384_pkg::K[rnd] + w_cur;
    s0 = sha384_pkg::rotr(v[0], 28) ^ sha384_pkg::rotr(v[0], 34) ^ sha384_pkg::rotr(v[0], 39);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  always_comb begin
    cst_next = cst;
    w_we = 1'b0;
    w_waddr = ld_cnt[6:3] - 4'd1;
    w_wdata = word_acc;
    w_raddr = rnd[3:0];
    done = 1'b0;
    case (cst)
      C_IDLE: begin
        if (ctl.start) begin
          cst_next = C_LOAD;
        end
      end
      C_LOAD: begin
        if (ld_cnt[2:0] == 3'd1 && ld_cnt > 8'd1) begin
          w_we = 1'b1;
        end
        if (ld_cnt == 8'd129) begin
          cst_next = C_R0;
        end
        w_raddr = rnd[3:0] + 4'd1;
      end
      C_R0: begin
        w_raddr = rnd[3:0] + 4'd14;
        cst_next = C_R1;
      end
      C_R1: begin
        w_raddr = rnd[3:0] + 4'd9;
        cst_next = C_R2;
      end
      C_R2: begin
        w_raddr = rnd[3:0];
        cst_next = C_R3;
      end
      C_R3: begin
        w_we = (rnd >= 7'd16);
        w_waddr = rnd[3:0];
        w_wdata = w_new;
        w_raddr = rnd[3:0] + 4'd2;
        cst_next = (rnd == 7'(sha384_pkg::Rounds - 1)) ? C_ADD : C_R0;
      end
      C_ADD: begin
        done = 1'b1;
        cst_next = C_IDLE;
      end
      default: cst_next = C_IDLE;
    endcase
  end

  assign busy = (cst != C_IDLE);
  assign buf_raddr = rd_cnt;
  assign dig_word = h[dig_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
    end else begin
      cst <= cst_next;
    end
    if (rst || hash_init) begin
      for (int i = 0; i < 8; i++) h[i] <= sha384_pkg::IV[i];
    end else if (cst == C_ADD) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
    case (cst)
      C_IDLE: begin
        rd_cnt <= 7'd0;
        ld_cnt <= 8'd0;
        rnd <= 7'd0;
        for (int i = 0; i < 8; i++) v[i] <= h[i];
      end
      C_LOAD: begin
        rd_cnt <= rd_cnt + 7'd1;
        ld_cnt <= ld_cnt + 8'd1;
        if (ld_cnt != 8'd0) begin
          word_acc <= {word_acc[55:0], buf_rdata};
        end
      end
      C_R0: x15 <= w_rdata;
      C_R1: x2 <= w_rdata;
      C_R2: x7 <= w_rdata;
      C_R3: begin
        rnd <= rnd + 7'd1;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/sha384_stream_hasher_top.sv
// A byte that fills a block holds off input for a compression (the buffer
// load, 80 rounds of window-RAM reads, then the add and update steps).
// A last beat adds padding up to the end of the block and a compression, done
// twice when 112 or more bytes are buffered, then six digest beats.
// Throughput: one byte per cycle inside a block; the compression blocks input.
// Reset: rst, synchronous, restores the SHA-384 IV and clears all counts.
module sha384_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // digest_word[63:0], word_index[66:64], zero fill
  output logic        m_axis_tlast    // last_word
);

  sha384_pkg::state_t st, st_next;
  sha384_pkg::ctl_t   ctl;

  logic [6:0]   fill;
  logic [127:0] bitlen;
  logic         second;
  logic [6:0]   pos;
  logic [2:0]   oidx;
  logic         core_busy, core_done, hash_init;
  logic [6:0]   core_raddr;
  logic [7:0]   buf_rdata;
  logic [63:0]  dig_word;
  logic         b_we;
  logic [6:0]   b_waddr;
  logic [7:0]   b_wdata, pad_byte;
  logic         acc;
  logic         pend_last, pad_run, final_blk;

  sha384_ram #(.Width(8), .Depth(sha384_pkg::BlockBytes)) u_buf (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(core_raddr), .rdata(buf_rdata)
  );

  sha384_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .buf_raddr(core_raddr), .buf_rdata(buf_rdata),
    .busy(core_busy), .done(core_done), .hash_init(hash_init),
    .dig_sel(oidx), .dig_word(dig_word)
  );

  assign acc = s_axis_tvalid && s_axis_tready;

  // length goes into this block unless the pad byte lands at or past the length field
  assign final_blk = second || (fill < 7'(sha384_pkg::LenStart));

  always_comb begin
    if (pos == fill && !second) begin
      pad_byte = sha384_pkg::PadByte;
    end else if (final_blk && pos >= 7'(sha384_pkg::LenStart)) begin
      pad_byte = bitlen[{~pos[3:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'd0;
    end
  end

  always_comb begin
    st_next = st;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    b_we = 1'b0;
    b_waddr = fill;
    b_wdata = s_axis_tdata;
    ctl = '0;
    hash_init = 1'b0;
    case (st)
      sha384_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (acc) begin
          b_we = s_axis_tuser;
          if (s_axis_tuser && fill == 7'd127) begin
            ctl.start = 1'b1;
            st_next = sha384_pkg::ST_LOAD;
          end else if (s_axis_tlast) begin
            st_next = sha384_pkg::ST_PAD;
          end
        end
      end
      sha384_pkg::ST_PAD: begin
        b_we = 1'b1;
        b_waddr = pos;
        b_wdata = pad_byte;
        if (pos == 7'd127) begin
          ctl.start = 1'b1;
          st_next = sha384_pkg::ST_LOAD;
        end
      end
      sha384_pkg::ST_LOAD: begin
        st_next = sha384_pkg::ST_ROUND;
      end
      sha384_pkg::ST_ROUND: begin
        if (core_done) begin
          st_next = sha384_pkg::ST_UPDATE;
        end
      end
      sha384_pkg::ST_UPDATE: begin
        if (!pend_last) begin
          st_next = sha384_pkg::ST_IDLE;
        end else if (pad_run && final_blk) begin
          st_next = sha384_pkg::ST_EMIT;
        end else begin
          st_next = sha384_pkg::ST_PAD;
        end
      end
      sha384_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready && oidx == 3'(sha384_pkg::DigestWords - 1)) begin
          hash_init = 1'b1;
          st_next = sha384_pkg::ST_IDLE;
        end
      end
      default: st_next = sha384_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sha384_pkg::ST_IDLE;
      fill <= 7'd0;
      bitlen <= '0;
      second <= 1'b0;
      pos <= 7'd0;
      oidx <= 3'd0;
      pend_last <= 1'b0;
      pad_run <= 1'b0;
    end else begin
      st <= st_next;
      case (st)
        sha384_pkg::ST_IDLE: begin
          pad_run <= 1'b0;
          if (acc) begin
            pend_last <= s_axis_tlast;
            pos <= s_axis_tuser ? fill + 7'd1 : fill;
            if (s_axis_tuser) begin
              fill <= fill + 7'd1;
              bitlen <= bitlen + 128'd8;
            end
          end
        end
        sha384_pkg::ST_PAD: begin
          pos <= pos + 7'd1;
          if (pos == 7'd127) begin
            pad_run <= 1'b1;
          end
        end
        sha384_pkg::ST_UPDATE: begin
          pos <= 7'd0;
          if (pend_last && pad_run && !final_blk) begin
            second <= 1'b1;
            fill <= 7'd0;
          end
        end
        sha384_pkg::ST_EMIT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'(sha384_pkg::DigestWords - 1)) begin
              oidx <= 3'd0;
              fill <= 7'd0;
              bitlen <= '0;
              second <= 1'b0;
              pend_last <= 1'b0;
              pad_run <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {5'd0, oidx, dig_word};
  assign m_axis_tlast = (oidx == 3'(sha384_pkg::DigestWords - 1));

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("input ready while emitting");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> oidx < 3'(sha384_pkg::DigestWords)) else $error("bad word index");
  a_core_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !core_busy) else $error("input taken during compression");

endmodule
